[hdl/clnw_pkg.sv]
// ----------------------------------------------------------------------------
// clnw_pkg
// Shared types, constants and lookup tables for the character LCD nibble
// writer.
// ----------------------------------------------------------------------------
package clnw_pkg;

    // Display geometry and string limit
    localparam int COLS       = 20;
    localparam int ROWS       = 4;
    localparam int MAX_STRING = 80;

    localparam int COL_W = 6;   // holds 0..COLS (COLS up to 40)
    localparam int ROW_W = 2;
    localparam int CNT_W = 7;   // holds 0..MAX_STRING (up to 127)

    typedef enum logic [1:0] {
        OP_CHAR   = 2'd0,
        OP_CURSOR = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_HOME   = 2'd3
    } t_op;

    localparam logic [7:0] INST_SET_DDRAM = 8'h80;
    localparam logic [7:0] INST_CLEAR     = 8'h01;
    localparam logic [7:0] INST_HOME      = 8'h02;
    localparam logic [7:0] CHAR_NUL       = 8'h00;
    localparam logic [7:0] CHAR_NEWLINE   = 8'h0A;

    // DDRAM start address of each display line
    localparam logic [3:0][7:0] LINE_ADDR = {8'h54, 8'h14, 8'h40, 8'h00};

    typedef logic [255:0][COL_W-1:0] t_col_tab;
    typedef logic [255:0][ROW_W-1:0] t_row_tab;

    function automatic t_col_tab f_col_tab();
        t_col_tab tab;
        for (int i = 0; i < 256; i++) begin
            tab[i] = COL_W'(i % COLS);
        end
        return tab;
    endfunction

    function automatic t_row_tab f_row_tab();
        t_row_tab tab;
        for (int i = 0; i < 256; i++) begin
            tab[i] = ROW_W'(i % ROWS);
        end
        return tab;
    endfunction

    // Byte-wide modulo lookups, built at elaboration
    localparam t_col_tab COL_MOD = f_col_tab();
    localparam t_row_tab ROW_MOD = f_row_tab();

    // One registered input command
    typedef struct packed {
        t_op        op;
        logic [7:0] char_code;
        logic [7:0] column;
        logic [7:0] row;
        logic       eos;
    } t_cmd;

    // One byte request handed to the serializer
    typedef struct packed {
        logic [7:0] value;
        logic       rs;
    } t_byte_req;

endpackage

[hdl/clnw_decode.sv]
// ----------------------------------------------------------------------------
// clnw_decode
// Turns one command into an instruction or data byte and keeps the cursor
// and string state. State advances when the command is taken.
// ----------------------------------------------------------------------------
module clnw_decode (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_take,
    input  clnw_pkg::t_cmd      i_cmd,
    output logic                o_emit,
    output clnw_pkg::t_byte_req o_req
);

    logic [clnw_pkg::COL_W-1:0] r_col, n_col;
    logic [clnw_pkg::ROW_W-1:0] r_row, n_row;
    logic [clnw_pkg::CNT_W-1:0] r_cnt, n_cnt;
    logic                       r_stopped, n_stopped;

    logic [clnw_pkg::COL_W-1:0] col_mod;
    logic [clnw_pkg::ROW_W-1:0] row_mod;
    logic [clnw_pkg::ROW_W-1:0] row_next;

    assign col_mod  = clnw_pkg::COL_MOD[i_cmd.column];
    assign row_mod  = clnw_pkg::ROW_MOD[i_cmd.row];
    assign row_next = (r_row == clnw_pkg::ROW_W'(clnw_pkg::ROWS - 1)) ?
                      '0 : r_row + 1'b1;

    always_comb begin
        n_col       = r_col;
        n_row       = r_row;
        n_cnt       = r_cnt;
        n_stopped   = r_stopped;
        o_emit      = 1'b0;
        o_req.value = '0;
        o_req.rs    = 1'b0;

        unique case (i_cmd.op)
            clnw_pkg::OP_CURSOR: begin
                n_row       = row_mod;
                n_col       = col_mod;
                o_emit      = 1'b1;
                o_req.value = clnw_pkg::INST_SET_DDRAM |
                              (clnw_pkg::LINE_ADDR[row_mod] + 8'(col_mod));
            end
            clnw_pkg::OP_CLEAR, clnw_pkg::OP_HOME: begin
                n_row       = '0;
                n_col       = '0;
                o_emit      = 1'b1;
                o_req.value = (i_cmd.op == clnw_pkg::OP_CLEAR) ?
                              clnw_pkg::INST_CLEAR : clnw_pkg::INST_HOME;
            end
            clnw_pkg::OP_CHAR: begin
                if (i_cmd.char_code == clnw_pkg::CHAR_NUL) begin
                    // terminator: ends the string silently
                    n_cnt     = '0;
                    n_stopped = 1'b0;
                end else begin
                    if (!r_stopped && r_cnt < clnw_pkg::CNT_W'(clnw_pkg::MAX_STRING)) begin
                        n_cnt  = r_cnt + 1'b1;
                        o_emit = 1'b1;
                        if (r_col >= clnw_pkg::COL_W'(clnw_pkg::COLS)) begin
                            // column limit: wrap to next line, drop char, stop string
                            n_row       = row_next;
                            n_col       = '0;
                            n_stopped   = 1'b1;
                            o_req.value = clnw_pkg::INST_SET_DDRAM |
                                          clnw_pkg::LINE_ADDR[row_next];
                        end else if (i_cmd.char_code == clnw_pkg::CHAR_NEWLINE) begin
                            n_row       = row_next;
                            n_col       = '0;
                            o_req.value = clnw_pkg::INST_SET_DDRAM |
                                          clnw_pkg::LINE_ADDR[row_next];
                        end else begin
                            n_col       = r_col + 1'b1;
                            o_req.value = i_cmd.char_code;
                            o_req.rs    = 1'b1;
                        end
                    end
                    if (i_cmd.eos) begin
                        n_cnt     = '0;
                        n_stopped = 1'b0;
                    end
                end
            end
            default: begin
                o_emit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col     <= '0;
            r_row     <= '0;
            r_cnt     <= '0;
            r_stopped <= 1'b0;
        end else if (i_take) begin
            r_col     <= n_col;
            r_row     <= n_row;
            r_cnt     <= n_cnt;
            r_stopped <= n_stopped;
        end
    end

endmodule

[hdl/clnw_serial.sv]
// ----------------------------------------------------------------------------
// clnw_serial
// Sends one byte as four expander beats: high nibble with enable high then
// low, then the low nibble the same way.
// ----------------------------------------------------------------------------
module clnw_serial (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  clnw_pkg::t_byte_req i_req,
    output logic                o_ready,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [3:0]          o_nibble,
    output logic                o_register_select,
    output logic                o_enable,
    output logic                o_last
);

    logic                r_busy;
    logic [1:0]          r_beat;
    clnw_pkg::t_byte_req r_req;

    logic beat_done;
    assign beat_done = r_busy && !i_stall;

    // free now, or the final beat leaves this cycle
    assign o_ready = !r_busy || (beat_done && r_beat == 2'd3);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_beat <= '0;
        end else if (i_load) begin
            r_busy <= 1'b1;
            r_beat <= '0;
        end else if (beat_done) begin
            if (r_beat == 2'd3) begin
                r_busy <= 1'b0;
            end
            r_beat <= r_beat + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_req <= i_req;
        end
    end

    assign o_valid           = r_busy;
    assign o_nibble          = r_beat[1] ? r_req.value[3:0] : r_req.value[7:4];
    assign o_register_select = r_req.rs;
    assign o_enable          = !r_beat[0];
    assign o_last            = (r_beat == 2'd3);

endmodule

[hdl/char_lcd_nibble_writer.sv]
// ----------------------------------------------------------------------------
// char_lcd_nibble_writer
// HD44780 4-bit expander text writer: one command in, four strobed nibble
// beats out for each byte it emits, with cursor and string tracking.
// ----------------------------------------------------------------------------
// A request passes the input register, then the serializer's byte register,
// before its first beat shows. Throughput is set by the nibble serializer,
// one beat per cycle while i_stall is low; requests with no output skip it.
// Reset (synchronous, active low) clears cursor to 0,0, string count and
// stop flag, and empties the input and output stages.
module char_lcd_nibble_writer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [1:0] i_operation,
    input  logic [7:0] i_char_code,
    input  logic [7:0] i_column,
    input  logic [7:0] i_row,
    input  logic       i_end_of_string,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [3:0] o_nibble,
    output logic       o_register_select,
    output logic       o_enable,
    output logic       o_last
);

    logic                r_in_valid;
    clnw_pkg::t_cmd      r_cmd;
    logic                take;
    logic                emit;
    logic                ser_ready;
    clnw_pkg::t_byte_req req;

    // a request leaves the input stage once the serializer can take its byte, or at once if it emits none
    assign take    = r_in_valid && (!emit || ser_ready);
    assign o_stall = r_in_valid && !take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_cmd.op        <= clnw_pkg::t_op'(i_operation);
            r_cmd.char_code <= i_char_code;
            r_cmd.column    <= i_column;
            r_cmd.row       <= i_row;
            r_cmd.eos       <= i_end_of_string;
        end
    end

    clnw_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take),
        .i_cmd   (r_cmd),
        .o_emit  (emit),
        .o_req   (req)
    );

    clnw_serial u_serial (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_load            (take && emit),
        .i_req             (req),
        .o_ready           (ser_ready),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_nibble          (o_nibble),
        .o_register_select (o_register_select),
        .o_enable          (o_enable),
        .o_last            (o_last)
    );

    // a run of four beats is never cut short
    a_run_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && !o_last |=> o_valid)
        else $error("beat run ended early");

    // enable alternates high/low within a run
    a_strobe_toggles: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && !o_last |=> o_enable == !$past(o_enable))
        else $error("enable strobe did not alternate");

    // the same nibble is held for the enable-low beat
    a_nibble_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && o_enable |=> o_nibble == $past(o_nibble))
        else $error("nibble changed across strobe");

    // a byte is loaded only when the serializer is free
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take && emit |-> !o_valid || (o_last && !i_stall))
        else $error("byte loaded over a busy run");

endmodule
